/* rtl/pot_to_midi_cc_conditioner_macros.svh */
// Assertion macros for the potentiometer to MIDI CC conditioner.
// Included by the top level; needs a clock named aclk and a reset named aresetn.
`ifndef POT_TO_MIDI_CC_CONDITIONER_MACROS_SVH
`define POT_TO_MIDI_CC_CONDITIONER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PTMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptmc assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent
`define PTMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptmc assertion failed (next cycle)");

`endif

/* rtl/ptmc_pkg.sv */
// Shared constants, types and register codes of the pot to MIDI CC conditioner.
// No dependencies; used by ptmc_div, ptmc_core and the top level.
`default_nettype none

package ptmc_pkg;

    // Build options
    localparam bit EXTERNAL_ADC = 1'b0;
    localparam int EXT_RAW_MAX  = 32767;
    localparam int HOLD_TICKS   = 300;
    localparam int SCALED_FULL  = 4096;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int RAW_W    = 13;
    localparam int CC_W     = 7;
    localparam int CHAN_W   = 5;
    localparam int CCNUM_W  = 8;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 13;
    localparam int IDLE_W   = $clog2(HOLD_TICKS + 1);

    // Divider sizing: external scaling and CC mapping share one unit
    localparam int EXT_W       = $clog2(EXT_RAW_MAX + 1);
    localparam int SCALE_SHIFT = $clog2(SCALED_FULL);
    localparam int SCALE_NUM_W = EXT_W + SCALE_SHIFT;
    localparam int MAP_NUM_W   = RAW_W + CC_W;
    localparam int DIV_W       = (SCALE_NUM_W > MAP_NUM_W) ? SCALE_NUM_W : MAP_NUM_W;
    localparam int DEN_W       = (EXT_W > RAW_W) ? EXT_W : RAW_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);

    localparam logic [IDLE_W-1:0]          HOLD_C     = IDLE_W'(HOLD_TICKS);
    localparam logic signed [SAMPLE_W-1:0] NOT_READY  = -16'sd255;
    localparam logic signed [SAMPLE_W-1:0] EXT_MAX_S  = SAMPLE_W'(EXT_RAW_MAX);
    localparam logic [CC_W-1:0]            CC_TOP     = '1;

    // Command codes carried in s_tuser
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ENABLED    = 3'd0,
        REG_ANALOG_MIN = 3'd1,
        REG_ANALOG_MAX = 3'd2,
        REG_CC_MIN     = 3'd3,
        REG_CC_MAX     = 3'd4,
        REG_MOVE_THR   = 3'd5,
        REG_CHANNEL    = 3'd6,
        REG_CC_NUMBER  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                enabled;
        logic [RAW_W-1:0]    analog_min;
        logic [RAW_W-1:0]    analog_max;
        logic [CC_W-1:0]     cc_min;
        logic [CC_W-1:0]     cc_max;
        logic [CC_W-1:0]     move_threshold;
        logic [CHAN_W-1:0]   midi_channel;
        logic [CCNUM_W-1:0]  controller_number;
    } cfg_t;

    // Divider control
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

    // Core status toward the top level
    typedef struct packed {
        logic              ready;
        logic              emit;
        logic [CC_W-1:0]   cc_value;
        logic [IDLE_W-1:0] idle_ticks;
    } core_stat_t;

endpackage

`default_nettype wire

/* rtl/ptmc_div.sv */
// Restoring serial divider: one quotient bit per cycle on unsigned operands.
// Depends on ptmc_pkg for widths and the request/response structs.
`default_nettype none

module ptmc_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ptmc_pkg::div_req_t           req,
    input  wire logic [ptmc_pkg::DIV_W-1:0]   dividend,  // top-aligned to req.steps bits
    input  wire logic [ptmc_pkg::DEN_W-1:0]   divisor,
    output ptmc_pkg::div_rsp_t                rsp,
    output logic [ptmc_pkg::DIV_W-1:0]        quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ptmc_pkg::CNT_W-1:0]    cnt_reg;
    logic [ptmc_pkg::DEN_W-1:0]    rem_reg;
    logic [ptmc_pkg::DIV_W-1:0]    q_reg;
    logic [ptmc_pkg::DEN_W-1:0]    den_reg;

    logic [ptmc_pkg::DEN_W:0]      trial;
    logic [ptmc_pkg::DEN_W:0]      trial_sub;
    logic                          ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, q_reg[ptmc_pkg::DIV_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - ptmc_pkg::CNT_W'(1);
                if (cnt_reg == ptmc_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in from the bottom as dividend bits leave the top
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[ptmc_pkg::DEN_W-1:0] : trial[ptmc_pkg::DEN_W-1:0];
            q_reg   <= {q_reg[ptmc_pkg::DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* rtl/ptmc_core.sv */
// Sequencer and state of the conditioner: window clamp, CC mapping, movement
// detection and hold timeout. Depends on ptmc_pkg; drives one ptmc_div.
`default_nettype none

module ptmc_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ptmc_pkg::cfg_t                 cfg,
    input  wire logic                           in_valid,
    input  wire logic                           in_command,
    input  wire logic signed [ptmc_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                           out_free,
    input  wire ptmc_pkg::div_rsp_t             div_rsp,
    input  wire logic [ptmc_pkg::DIV_W-1:0]     div_quotient,
    output ptmc_pkg::div_req_t                  div_req,
    output logic [ptmc_pkg::DIV_W-1:0]          div_dividend,
    output logic [ptmc_pkg::DEN_W-1:0]          div_divisor,
    output ptmc_pkg::core_stat_t                stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CLAMP,
        ST_MAP,
        ST_MUL,
        ST_DIV,
        ST_DECIDE
    } state_t;

    state_t                                   state_reg;
    logic signed [ptmc_pkg::SAMPLE_W-1:0]     pre_reg;
    logic [ptmc_pkg::RAW_W-1:0]               x_reg;
    logic [ptmc_pkg::RAW_W-1:0]               dx_mag_reg;
    logic [ptmc_pkg::RAW_W-1:0]               dn_mag_reg;
    logic [ptmc_pkg::CC_W-1:0]                dc_mag_reg;
    logic                                     neg_reg;
    logic [ptmc_pkg::CC_W-1:0]                cc_reg;
    logic [ptmc_pkg::RAW_W-1:0]               last_raw_reg;
    logic [ptmc_pkg::CC_W-1:0]                last_cc_reg;
    logic [ptmc_pkg::IDLE_W-1:0]              idle_reg;

    logic                                     accept;
    logic                                     not_ready;
    logic [ptmc_pkg::EXT_W-1:0]               ext_clamped;
    logic signed [ptmc_pkg::SAMPLE_W-1:0]     amin_s;
    logic signed [ptmc_pkg::SAMPLE_W-1:0]     amax_s;
    logic [ptmc_pkg::RAW_W-1:0]               x_clamped;
    logic signed [ptmc_pkg::RAW_W:0]          dx;
    logic signed [ptmc_pkg::RAW_W:0]          dn;
    logic signed [ptmc_pkg::CC_W:0]           dc;
    logic [ptmc_pkg::MAP_NUM_W-1:0]           product;
    logic [ptmc_pkg::MAP_NUM_W-1:0]           q_map;
    logic [ptmc_pkg::MAP_NUM_W:0]             q_sum;
    logic [ptmc_pkg::CC_W-1:0]                cc_mapped;
    logic [ptmc_pkg::CC_W-1:0]                cc_diff;
    logic                                     moved;
    logic [ptmc_pkg::IDLE_W-1:0]              idle_eff;
    logic                                     send;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Sample conditioning terms
    always_comb begin
        not_ready = (in_sample == ptmc_pkg::NOT_READY);
        if (in_sample < 0) begin
            ext_clamped = '0;
        end else if (in_sample > ptmc_pkg::EXT_MAX_S) begin
            ext_clamped = ptmc_pkg::EXT_W'(ptmc_pkg::EXT_RAW_MAX);
        end else begin
            ext_clamped = in_sample[ptmc_pkg::EXT_W-1:0];
        end
        amin_s = {{(ptmc_pkg::SAMPLE_W-ptmc_pkg::RAW_W){1'b0}}, cfg.analog_min};
        amax_s = {{(ptmc_pkg::SAMPLE_W-ptmc_pkg::RAW_W){1'b0}}, cfg.analog_max};
        if (pre_reg < amin_s) begin
            x_clamped = cfg.analog_min;
        end else if (pre_reg > amax_s) begin
            x_clamped = cfg.analog_max;
        end else begin
            x_clamped = pre_reg[ptmc_pkg::RAW_W-1:0];
        end
    end

    // Signed differences of the linear map, split into magnitude and sign
    always_comb begin
        dx = $signed({1'b0, x_reg}) - $signed({1'b0, cfg.analog_min});
        dn = $signed({1'b0, cfg.analog_max}) - $signed({1'b0, cfg.analog_min});
        dc = $signed({1'b0, cfg.cc_max}) - $signed({1'b0, cfg.cc_min});
        product = ptmc_pkg::MAP_NUM_W'(dx_mag_reg) * ptmc_pkg::MAP_NUM_W'(dc_mag_reg);
    end

    // Apply sign to the quotient, add cc_min, saturate to 0..127
    always_comb begin
        q_map = div_quotient[ptmc_pkg::MAP_NUM_W-1:0];
        q_sum = {1'b0, q_map} + (ptmc_pkg::MAP_NUM_W+1)'(cfg.cc_min);
        if (neg_reg) begin
            if (q_map > ptmc_pkg::MAP_NUM_W'(cfg.cc_min)) begin
                cc_mapped = '0;
            end else begin
                cc_mapped = cfg.cc_min - q_map[ptmc_pkg::CC_W-1:0];
            end
        end else begin
            if (q_sum > (ptmc_pkg::MAP_NUM_W+1)'(ptmc_pkg::CC_TOP)) begin
                cc_mapped = ptmc_pkg::CC_TOP;
            end else begin
                cc_mapped = q_sum[ptmc_pkg::CC_W-1:0];
            end
        end
    end

    // Movement and hold decision
    always_comb begin
        cc_diff  = (cc_reg > last_cc_reg) ? cc_reg - last_cc_reg : last_cc_reg - cc_reg;
        moved    = (cc_diff > cfg.move_threshold);
        idle_eff = moved ? '0 : idle_reg;
        send     = (idle_eff < ptmc_pkg::HOLD_C);
    end

    // Divider requests: external scaling from idle, CC mapping from the multiply step
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = ptmc_pkg::CNT_W'(ptmc_pkg::MAP_NUM_W);
        div_dividend  = ptmc_pkg::DIV_W'(product) << (ptmc_pkg::DIV_W - ptmc_pkg::MAP_NUM_W);
        div_divisor   = ptmc_pkg::DEN_W'(dn_mag_reg);
        if (state_reg == ST_IDLE) begin
            div_req.start = ptmc_pkg::EXTERNAL_ADC && accept
                            && (in_command == ptmc_pkg::CMD_SAMPLE) && cfg.enabled
                            && !not_ready;
            div_req.steps = ptmc_pkg::CNT_W'(ptmc_pkg::SCALE_NUM_W);
            div_dividend  = ptmc_pkg::DIV_W'(ext_clamped)
                            << (ptmc_pkg::SCALE_SHIFT + ptmc_pkg::DIV_W - ptmc_pkg::SCALE_NUM_W);
            div_divisor   = ptmc_pkg::DEN_W'(ptmc_pkg::EXT_RAW_MAX);
        end else if (state_reg == ST_MUL) begin
            div_req.start = 1'b1;
        end
    end

    // Sequencer and registered state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_raw_reg <= '0;
            last_cc_reg  <= '0;
            idle_reg     <= ptmc_pkg::HOLD_C;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (in_command == ptmc_pkg::CMD_TICK) begin
                            if (idle_reg < ptmc_pkg::HOLD_C) begin
                                idle_reg <= idle_reg + ptmc_pkg::IDLE_W'(1);
                            end
                        end else if (cfg.enabled) begin
                            if (ptmc_pkg::EXTERNAL_ADC) begin
                                if (not_ready) begin
                                    // reuse last sent raw value, no window clamp
                                    x_reg     <= last_raw_reg;
                                    state_reg <= ST_MAP;
                                end else begin
                                    state_reg <= ST_SCALE;
                                end
                            end else begin
                                pre_reg   <= in_sample;
                                state_reg <= ST_CLAMP;
                            end
                        end
                    end
                end
                ST_SCALE: begin
                    if (div_rsp.done) begin
                        pre_reg   <= {{(ptmc_pkg::SAMPLE_W-ptmc_pkg::RAW_W){1'b0}},
                                      div_quotient[ptmc_pkg::RAW_W-1:0]};
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    x_reg     <= x_clamped;
                    state_reg <= ST_MAP;
                end
                ST_MAP: begin
                    dx_mag_reg <= dx[ptmc_pkg::RAW_W] ? ptmc_pkg::RAW_W'(-dx)
                                                      : dx[ptmc_pkg::RAW_W-1:0];
                    dn_mag_reg <= dn[ptmc_pkg::RAW_W] ? ptmc_pkg::RAW_W'(-dn)
                                                      : dn[ptmc_pkg::RAW_W-1:0];
                    dc_mag_reg <= dc[ptmc_pkg::CC_W] ? ptmc_pkg::CC_W'(-dc)
                                                     : dc[ptmc_pkg::CC_W-1:0];
                    neg_reg    <= dx[ptmc_pkg::RAW_W] ^ dn[ptmc_pkg::RAW_W] ^ dc[ptmc_pkg::CC_W];
                    if (cfg.analog_min == cfg.analog_max) begin
                        // degenerate window maps to cc_min
                        cc_reg    <= cfg.cc_min;
                        state_reg <= ST_DECIDE;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        cc_reg    <= cc_mapped;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (!send) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        last_raw_reg <= x_reg;
                        last_cc_reg  <= cc_reg;
                        idle_reg     <= idle_eff;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.ready      = (state_reg == ST_IDLE);
    assign stat.emit       = (state_reg == ST_DECIDE) && send && out_free;
    assign stat.cc_value   = cc_reg;
    assign stat.idle_ticks = idle_reg;

endmodule

`default_nettype wire

/* rtl/pot_to_midi_cc_conditioner.sv */
// Potentiometer to MIDI control-change conditioner, top level.
// Uses ptmc_pkg, ptmc_core, ptmc_div and pot_to_midi_cc_conditioner_macros.svh.
//
// Input stream: s_tuser is the command (0 = 1 ms tick, 1 = sample), s_tdata[15:0]
// the signed converter sample. Output stream: one control-change transfer per
// sample that passes the hold timeout, m_tdata = {pad, cc_value, cc_number,
// channel}. Config: cfg_wr_en/cfg_index/cfg_wdata write one register per
// cycle; write only while the block is idle.
//
// A tick leaves s_tready high. A sample holds s_tready low until it is done: it
// passes the clamp, map, multiply, divide and decide states before m_tvalid (equal
// analog bounds skip multiply and divide), and the serial divider produces one
// quotient bit per cycle for the 20-bit CC map. External-converter builds add
// a scaling division first; a not-ready sample skips that division and the clamp.
//
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// last-sent values and saturates the idle counter, so no message goes out
// until the pot moves. The output register keeps one result; while the
// receiver stalls, the next item is still taken, and a following result
// waits inside the core until the output register frees up.
`default_nettype none

`include "pot_to_midi_cc_conditioner_macros.svh"

module pot_to_midi_cc_conditioner (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] sample
    input  wire logic                          s_tuser,   // [0] command
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,   // [4:0] channel, [12:5] cc_number,
                                                          // [19:13] cc_value, [23:20] zero
    // Configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic [ptmc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [ptmc_pkg::CFG_W-1:0]    cfg_wdata
);

    ptmc_pkg::cfg_t                  cfg_reg;
    logic                            m_valid_reg;
    logic [ptmc_pkg::CHAN_W-1:0]     m_chan_reg;
    logic [ptmc_pkg::CCNUM_W-1:0]    m_num_reg;
    logic [ptmc_pkg::CC_W-1:0]       m_cc_reg;

    ptmc_pkg::core_stat_t            stat;
    ptmc_pkg::div_req_t              div_req;
    ptmc_pkg::div_rsp_t              div_rsp;
    logic [ptmc_pkg::DIV_W-1:0]      div_dividend;
    logic [ptmc_pkg::DEN_W-1:0]      div_divisor;
    logic [ptmc_pkg::DIV_W-1:0]      div_quotient;
    logic                            out_free;

    logic                            tick_xfer;
    logic                            smp_xfer;
    logic [ptmc_pkg::IDLE_W-1:0]     idle_inc;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled           <= 1'b1;
            cfg_reg.analog_min        <= '0;
            cfg_reg.analog_max        <= ptmc_pkg::RAW_W'(ptmc_pkg::SCALED_FULL);
            cfg_reg.cc_min            <= '0;
            cfg_reg.cc_max            <= ptmc_pkg::CC_TOP;
            cfg_reg.move_threshold    <= ptmc_pkg::CC_W'(1);
            cfg_reg.midi_channel      <= ptmc_pkg::CHAN_W'(1);
            cfg_reg.controller_number <= '1;
        end else if (cfg_wr_en) begin
            unique case (ptmc_pkg::reg_idx_t'(cfg_index))
                ptmc_pkg::REG_ENABLED:    cfg_reg.enabled <= cfg_wdata[0];
                ptmc_pkg::REG_ANALOG_MIN: cfg_reg.analog_min <= cfg_wdata;
                ptmc_pkg::REG_ANALOG_MAX: cfg_reg.analog_max <= cfg_wdata;
                ptmc_pkg::REG_CC_MIN:     cfg_reg.cc_min <= cfg_wdata[ptmc_pkg::CC_W-1:0];
                ptmc_pkg::REG_CC_MAX:     cfg_reg.cc_max <= cfg_wdata[ptmc_pkg::CC_W-1:0];
                ptmc_pkg::REG_MOVE_THR: begin
                    cfg_reg.move_threshold <= cfg_wdata[ptmc_pkg::CC_W-1:0];
                end
                ptmc_pkg::REG_CHANNEL: begin
                    cfg_reg.midi_channel <= cfg_wdata[ptmc_pkg::CHAN_W-1:0];
                end
                ptmc_pkg::REG_CC_NUMBER: begin
                    cfg_reg.controller_number <= cfg_wdata[ptmc_pkg::CCNUM_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    ptmc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_command   (s_tuser),
        .in_sample    (s_tdata),
        .out_free     (out_free),
        .div_rsp      (div_rsp),
        .div_quotient (div_quotient),
        .div_req      (div_req),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .stat         (stat)
    );

    ptmc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.emit) begin
            m_chan_reg <= cfg_reg.midi_channel;
            m_num_reg  <= cfg_reg.controller_number;
            m_cc_reg   <= stat.cc_value;
        end
    end

    assign s_tready = stat.ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_cc_reg, m_num_reg, m_chan_reg};

    // Terms for the checks
    assign tick_xfer = s_tvalid && s_tready && (s_tuser == ptmc_pkg::CMD_TICK)
                       && (stat.idle_ticks < ptmc_pkg::HOLD_C);
    assign smp_xfer  = s_tvalid && s_tready && (s_tuser == ptmc_pkg::CMD_SAMPLE)
                       && cfg_reg.enabled;
    assign idle_inc  = stat.idle_ticks + ptmc_pkg::IDLE_W'(1);

    // Checks
    `PTMC_ASSERT_NEXT(a_tick_counts, tick_xfer, stat.idle_ticks == $past(idle_inc))
    `PTMC_ASSERT_NEXT(a_sample_busy, smp_xfer, !s_tready)
    `PTMC_ASSERT_NEXT(a_emit_shows, stat.emit, m_tvalid && (m_tdata[19:13] == $past(stat.cc_value)))
    `PTMC_ASSERT_NOW(a_emit_room, stat.emit, !s_tready)

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for pot_to_midi_cc_conditioner: directed and random
// tick/sample streams, checked against an in-bench model of the conditioner.
// Depends on ptmc_pkg and the pot_to_midi_cc_conditioner RTL.
`default_nettype none

module tb;
    import ptmc_pkg::*;

    // Expected control-change message, one per predicted transfer
    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [CCNUM_W-1:0] cc_number;
        logic [CC_W-1:0]    cc_value;
    } cc_msg_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              s_tuser   = CMD_TICK;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_ENABLED;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Model copy of the registers
    logic               proc_en;
    logic [RAW_W-1:0]   win_lo, win_hi;
    logic [CC_W-1:0]    cc_lo, cc_hi, move_thr;
    logic [CHAN_W-1:0]  chan;
    logic [CCNUM_W-1:0] cc_num;
    // Model copy of the state
    logic [RAW_W-1:0]   sent_raw;
    logic [CC_W-1:0]    sent_cc;
    int                 idle_ms;

    cc_msg_t cc_msgs_due[$];
    int      err_count    = 0;
    int      items_sent   = 0;
    int      msgs_checked = 0;
    int      cfg_writes   = 0;
    bit      src_gaps     = 1'b0;
    bit      snk_stalls   = 1'b0;
    int      stall_left   = 0;

    pot_to_midi_cc_conditioner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Conditioner model: tick advances the hold counter, a sample may give a message
    function automatic bit predict_cc_msg(input logic cmd, input logic signed [15:0] smp,
                                          output cc_msg_t msg);
        longint pot, v, lo, hi, cmin, cmax;
        logic [CC_W-1:0] cc, diff;
        msg = '0;
        if (cmd == CMD_TICK) begin
            if (idle_ms < HOLD_TICKS) idle_ms++;
            return 1'b0;
        end
        if (!proc_en) return 1'b0;
        lo   = win_lo;
        hi   = win_hi;
        cmin = cc_lo;
        cmax = cc_hi;
        // not-ready code reuses the last raw value, no window clamp
        if (EXTERNAL_ADC && smp == NOT_READY) begin
            pot = sent_raw;
        end else begin
            pot = smp;
            if (EXTERNAL_ADC) begin
                if (pot < 0) pot = 0;
                if (pot > EXT_RAW_MAX) pot = EXT_RAW_MAX;
                pot = (pot * SCALED_FULL) / EXT_RAW_MAX;
            end
            if (pot < lo) pot = lo;
            else if (pot > hi) pot = hi;
        end
        // linear map, truncating toward zero, then saturate to 0..127
        if (lo == hi) v = cmin;
        else v = ((pot - lo) * (cmax - cmin)) / (hi - lo) + cmin;
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        cc   = v[CC_W-1:0];
        diff = (cc > sent_cc) ? cc - sent_cc : sent_cc - cc;
        if (diff > move_thr) idle_ms = 0;
        if (idle_ms < HOLD_TICKS) begin
            msg.channel   = chan;
            msg.cc_number = cc_num;
            msg.cc_value  = cc;
            sent_raw      = pot[RAW_W-1:0];
            sent_cc       = cc;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Write all eight registers, one per cycle, and mirror them in the model
    task automatic write_settings(input int unsigned vals[8]);
        reg_idx_t idx;
        for (int i = 0; i < 8; i++) begin
            idx = reg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i][CFG_W-1:0];
            case (idx)
                REG_ENABLED:    proc_en  = vals[i][0];
                REG_ANALOG_MIN: win_lo   = vals[i][RAW_W-1:0];
                REG_ANALOG_MAX: win_hi   = vals[i][RAW_W-1:0];
                REG_CC_MIN:     cc_lo    = vals[i][CC_W-1:0];
                REG_CC_MAX:     cc_hi    = vals[i][CC_W-1:0];
                REG_MOVE_THR:   move_thr = vals[i][CC_W-1:0];
                REG_CHANNEL:    chan     = vals[i][CHAN_W-1:0];
                REG_CC_NUMBER:  cc_num   = vals[i][CCNUM_W-1:0];
                default: ;
            endcase
            cfg_writes++;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Drive one item; the caller either sends another or drains afterwards
    task automatic send_item(input logic cmd, input logic [15:0] smp);
        cc_msg_t msg;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (predict_cc_msg(cmd, $signed(smp), msg)) cc_msgs_due.push_back(msg);
    endtask

    // Stop the stream, wait for all messages, then let a silent sample finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cc_msgs_due.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        int unsigned lo, hi;
        lo = (win_lo < win_hi) ? win_lo : win_hi;
        hi = (win_lo < win_hi) ? win_hi : win_lo;
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2, 3, 4: return 16'($urandom_range(0, SCALED_FULL));
            5, 6:    return 16'($urandom_range(lo, hi));
            7: begin
                // wobble around the window edges
                if ($urandom_range(0, 1)) return 16'(lo + $urandom_range(0, 40) - 20);
                return 16'(hi + $urandom_range(0, 40) - 20);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'(SCALED_FULL);
                    4: return NOT_READY;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned rand_raw();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return SCALED_FULL;
            default: return $urandom_range(0, SCALED_FULL);
        endcase
    endfunction

    function automatic int unsigned rand_cc();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 127;
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    // Result sink: random stall bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (snk_stalls && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input cc_msg_t want, input cc_msg_t got);
        err_count++;
        if (err_count <= 10)
            $display("tb: %s at %0t: expected ch=%0d num=%0d val=%0d, got ch=%0d num=%0d val=%0d",
                     what, $time, want.channel, want.cc_number, want.cc_value,
                     got.channel, got.cc_number, got.cc_value);
    endtask

    // Check each result transfer against the oldest expected message
    always @(posedge aclk) begin : check_results
        cc_msg_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.channel   = m_tdata[4:0];
            got.cc_number = m_tdata[12:5];
            got.cc_value  = m_tdata[19:13];
            msgs_checked++;
            if (cc_msgs_due.size() == 0) begin
                note_mismatch("unexpected message", '0, got);
            end else begin
                want = cc_msgs_due.pop_front();
                if (got.channel !== want.channel)
                    note_mismatch("channel mismatch", want, got);
                else if (got.cc_number !== want.cc_number)
                    note_mismatch("cc_number mismatch", want, got);
                else if (got.cc_value !== want.cc_value)
                    note_mismatch("cc_value mismatch", want, got);
            end
        end
    end

    // Saturated hold counter after reset: only a real move gives a message
    task automatic test_quiet_after_reset();
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'd64);      // one step of CC, not above threshold
        send_item(CMD_TICK,   16'h0000);
        send_item(CMD_SAMPLE, 16'h7FFF);    // full-scale move
        send_item(CMD_SAMPLE, 16'd4095);
        send_item(CMD_SAMPLE, 16'(SCALED_FULL));
        send_item(CMD_SAMPLE, NOT_READY);
        send_item(CMD_SAMPLE, 16'd2048);
        send_item(CMD_TICK,   16'hFFFF);
        drain();
    endtask

    // Disabled block ignores samples but ticks still count
    task automatic test_enable_gate();
        write_settings('{0, 0, 4096, 0, 127, 1, 1, 255});
        send_item(CMD_SAMPLE, 16'h7FFF);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_TICK,   16'h0000);
        drain();
        write_settings('{1, 0, 4096, 0, 127, 1, 1, 255});
        send_item(CMD_SAMPLE, 16'd1000);
        drain();
    endtask

    // Equal analog bounds, then reversed analog and CC windows
    task automatic test_window_corners();
        write_settings('{1, 2000, 2000, 5, 100, 0, 16, 0});
        send_item(CMD_SAMPLE, 16'd0);
        send_item(CMD_SAMPLE, 16'd4096);
        send_item(CMD_SAMPLE, 16'h8000);
        drain();
        write_settings('{1, 3000, 1000, 127, 0, 0, 9, 128});
        send_item(CMD_SAMPLE, 16'd0);
        send_item(CMD_SAMPLE, 16'd4096);
        send_item(CMD_SAMPLE, 16'd2000);
        send_item(CMD_SAMPLE, 16'h7FFF);
        drain();
    endtask

    // Messages stop once the counter reaches the hold time without movement
    task automatic test_hold_timeout();
        write_settings('{1, 0, 4096, 0, 127, 0, 3, 7});
        send_item(CMD_SAMPLE, 16'd0);
        send_item(CMD_SAMPLE, 16'd4096);
        drain();
        write_settings('{1, 0, 4096, 0, 127, 127, 3, 7});
        for (int i = 0; i < HOLD_TICKS + 20; i++) begin
            send_item(CMD_TICK, 16'($urandom));
            if (i % 20 == 0) send_item(CMD_SAMPLE, 16'($urandom_range(0, SCALED_FULL)));
        end
        drain();
    endtask

    // Random settings, each followed by a mixed stream of ticks and samples
    task automatic test_random_settings();
        int unsigned vals[8];
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: vals = '{1, 0, 4096, 0, 127, 0, 16, 0};
                1: vals = '{1, 4096, 0, 127, 0, 1, 1, 255};
                2: vals = '{0, rand_raw(), rand_raw(), rand_cc(), rand_cc(), 2, 5, 60};
                default: begin
                    vals[0] = ($urandom_range(0, 9) != 0);
                    vals[1] = rand_raw();
                    vals[2] = rand_raw();
                    vals[3] = rand_cc();
                    vals[4] = rand_cc();
                    vals[5] = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 8);
                    vals[6] = $urandom_range(1, 16);
                    vals[7] = $urandom_range(0, 255);
                end
            endcase
            write_settings(vals);
            // no idling in the closing phase
            src_gaps   = (ph < 11) && ($urandom_range(0, 3) != 0);
            snk_stalls = (ph < 11) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 65; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    repeat ($urandom_range(20, 60)) send_item(CMD_TICK, 16'($urandom));
                end else if ($urandom_range(0, 3) == 0) begin
                    send_item(CMD_TICK, 16'($urandom));
                end else begin
                    send_item(CMD_SAMPLE, rand_sample());
                end
            end
            drain();
        end
    endtask

    initial begin
        proc_en  = 1'b1;
        win_lo   = '0;
        win_hi   = RAW_W'(SCALED_FULL);
        cc_lo    = '0;
        cc_hi    = CC_TOP;
        move_thr = CC_W'(1);
        chan     = CHAN_W'(1);
        cc_num   = '1;
        sent_raw = '0;
        sent_cc  = '0;
        idle_ms  = HOLD_TICKS;

        repeat (3) @(posedge aclk);
        aresetn    <= 1'b1;
        @(posedge aclk);
        src_gaps   = 1'b1;
        snk_stalls = 1'b1;

        test_quiet_after_reset();
        test_enable_gate();
        test_window_corners();
        test_hold_timeout();
        test_random_settings();

        $display("tb: %0d items sent, %0d messages checked, %0d register writes",
                 items_sent, msgs_checked, cfg_writes);
        $display("tb: covered hold timeout, enable gate, equal and reversed windows");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", err_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/ptmc_pkg.sv
rtl/ptmc_div.sv
rtl/ptmc_core.sv
rtl/pot_to_midi_cc_conditioner.sv
tb/tb.sv
